### rtl/icm_pkg.sv
// Package for the io completion matcher: field widths, command codes, types.
// No dependencies; used by every module of the block but icm_ram.
package icm_pkg;

    localparam int W_SEQ   = 32;
    localparam int W_TIME  = 48;
    localparam int W_LBA   = 48;
    localparam int W_LEN   = 32;
    localparam int W_ATTRS = 46;
    localparam int W_ERR   = 8;
    localparam int W_DEPTH = 16;
    localparam int W_CMD   = 2;
    localparam int W_IDATA = 200;
    localparam int W_ODATA = 264;
    localparam int DEF_TABLE_DEPTH = 64;

    localparam logic [W_CMD-1:0] CMD_SUBMIT = 2'd0;
    localparam logic [W_CMD-1:0] CMD_COMPL  = 2'd1;
    localparam logic [W_CMD-1:0] CMD_DRAIN  = 2'd2;

    // attrs: class 7..0, operation 11..8, flush 12, fua 13, device 29..14, depth 45..30
    typedef struct packed {
        logic [W_CMD-1:0]   cmd;
        logic [W_SEQ-1:0]   seq;
        logic [W_TIME-1:0]  t;
        logic [W_LBA-1:0]   lba;
        logic [W_LEN-1:0]   len;
        logic [W_ATTRS-1:0] attrs;
        logic [W_ERR-1:0]   err;
    } t_item;

    typedef struct packed {
        logic [W_ATTRS-1:0] attrs;
        logic [W_LEN-1:0]   len;
        logic [W_LBA-1:0]   lba;
        logic [W_TIME-1:0]  start;
        logic [W_SEQ-1:0]   seq;
    } t_entry;

    typedef struct packed {
        logic [W_ERR-1:0]  err;
        logic [W_TIME-1:0] lat;
    } t_result;

endpackage

### rtl/io_completion_matcher.sv
// IO completion matcher top level. Depends on icm_pkg, icm_front, icm_fifo, icm_back, icm_ram.
// A word passes the two-entry queue to the back; the back stores a submit (retiring the oldest
// entry first when the table is full), walks the table on a completion, then retires done words.
// How long an item takes depends on the table walk and on output stalls.
// The front accepts a word per cycle until the two-entry queue fills.
// Reset (i_rst_n low, synchronous) empties table, queue and output; time base clears.
module io_completion_matcher
    import icm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // seq_id, timestamp, lba, length, io_class, operation, flush_flag, fua_flag,
    // device_id, error_code, zero pad
    input  logic [W_IDATA-1:0] s_axis_tdata,
    // command
    input  logic [W_CMD-1:0]   s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // out_seq_id, start_time, out_lba, out_length, out_io_class, out_operation,
    // out_flags, out_device_id, queue_depth, latency, out_error, zero pad
    output logic [W_ODATA-1:0] m_axis_tdata,
    output logic               m_axis_tlast
);

    t_item f_item, q_item;
    logic  f_push, q_full, q_valid, q_pop;
    logic [$clog2(TABLE_DEPTH+1)-1:0] count;

    // Classify and rebase incoming words.
    icm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_tvalid(s_axis_tvalid), .o_tready(s_axis_tready),
        .i_tdata(s_axis_tdata), .i_tuser(s_axis_tuser),
        .i_full(q_full), .o_push(f_push), .o_item(f_item)
    );

    // Decouple front from the table sequencer.
    icm_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(f_push), .i_data(f_item), .o_full(q_full),
        .o_valid(q_valid), .o_data(q_item), .i_pop(q_pop)
    );

    // Match and retire against the table.
    icm_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .i_item(q_item), .o_pop(q_pop),
        .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_tdata(m_axis_tdata), .o_tlast(m_axis_tlast), .o_count(count)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= ($clog2(TABLE_DEPTH+1))'(TABLE_DEPTH))
        else $error("table count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (count == $past(count) || count == $past(count) + 1'b1
             || count == $past(count) - 1'b1))
        else $error("table count jumped");

    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[174]) |-> (m_axis_tdata[262:207] == '0))
        else $error("unmatched word carries latency or error");

endmodule

### rtl/icm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module icm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/icm_fifo.sv
// Two-entry queue between front and back of the matcher.
// Depends on icm_pkg for the item type.
module icm_fifo
    import icm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_data,
    input  logic  i_pop
);

    t_item       r_slot [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rp];

endmodule

### rtl/icm_front.sv
// Front of the matcher: accept words, rebase time, track outstanding depth.
// Depends on icm_pkg; feeds icm_fifo.
module icm_front
    import icm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tvalid,
    output logic               o_tready,
    input  logic [W_IDATA-1:0] i_tdata,
    input  logic [W_CMD-1:0]   i_tuser,
    input  logic               i_full,
    output logic               o_push,
    output t_item              o_item
);

    logic [W_TIME-1:0]  r_tb;
    logic [W_DEPTH-1:0] r_outst, n_outst;
    logic [W_TIME-1:0]  ts, base;
    logic               acc, timed;

    assign o_tready = !i_full;
    assign acc      = i_tvalid && !i_full;
    assign timed    = (i_tuser == CMD_SUBMIT) || (i_tuser == CMD_COMPL);
    assign ts       = i_tdata[79:32];
    assign base     = (r_tb == '0) ? ts : r_tb;

    always_comb begin
        n_outst = r_outst;
        if (i_tuser == CMD_SUBMIT && r_outst != '1) begin
            n_outst = r_outst + 1'b1;
        end else if (i_tuser == CMD_COMPL && r_outst != '0) begin
            n_outst = r_outst - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tb    <= '0;
            r_outst <= '0;
        end else if (acc && timed) begin
            r_tb    <= base;
            r_outst <= n_outst;
        end
    end

    // Drop command 3 here; it never reaches the back.
    assign o_push       = acc && (timed || i_tuser == CMD_DRAIN);
    assign o_item.cmd   = i_tuser;
    assign o_item.seq   = i_tdata[31:0];
    assign o_item.t     = ts - base;
    assign o_item.lba   = i_tdata[127:80];
    assign o_item.len   = i_tdata[159:128];
    assign o_item.attrs = {n_outst, i_tdata[189:174], i_tdata[173], i_tdata[172],
                           i_tdata[171:168], i_tdata[167:160]};
    assign o_item.err   = i_tdata[197:190];

endmodule

### rtl/icm_back.sv
// Back of the matcher: table sequencer for store, match walk and in-order retire.
// Depends on icm_pkg and icm_ram; drives the output register.
module icm_back
    import icm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  t_item                             i_item,
    output logic                              o_pop,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output logic [W_ODATA-1:0]                o_tdata,
    output logic                              o_tlast,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]  o_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL  = CW'(TABLE_DEPTH);
    localparam logic [AW-1:0] LASTI = AW'(TABLE_DEPTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0, S_WRD = 3'd1, S_WCMP = 3'd2, S_CHK = 3'd3,
                           S_RRD = 3'd4, S_ROUT = 3'd5, S_SWR = 3'd6;

    logic [2:0]             r_state;
    logic [AW-1:0]          r_head, r_tail, r_wptr;
    logic [CW-1:0]          r_count, r_k;
    logic [TABLE_DEPTH-1:0] r_done;
    t_item                  r_cur;
    logic                   r_oval, r_olast;
    logic [W_ODATA-1:0]     r_odata;

    t_entry  ent_w, ent_r;
    t_result res_w, res_r;
    logic    m_we, m_re, l_we, l_re;
    logic [AW-1:0] m_raddr, head_nx;
    logic    out_free, d;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == LASTI) ? '0 : p + 1'b1;
    endfunction

    assign ent_w   = '{attrs: r_cur.attrs, len: r_cur.len, lba: r_cur.lba,
                       start: r_cur.t, seq: r_cur.seq};
    assign res_w   = '{err: r_cur.err, lat: r_cur.t - ent_r.start};
    assign m_we    = (r_state == S_SWR);
    assign m_re    = (r_state == S_WRD) || (r_state == S_RRD);
    assign m_raddr = (r_state == S_WRD) ? r_wptr : r_head;
    assign l_re    = (r_state == S_RRD);
    assign l_we    = (r_state == S_WCMP) && (ent_r.seq <= r_cur.seq) && !r_done[r_wptr]
                     && (ent_r.lba == r_cur.lba) && (ent_r.len == r_cur.len);
    assign head_nx  = inc(r_head);
    assign out_free = !r_oval || i_tready;
    assign d        = r_done[r_head];

    icm_ram #(.WIDTH($bits(t_entry)), .DEPTH(TABLE_DEPTH)) u_ent (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(r_tail), .i_wdata(ent_w),
        .i_re(m_re), .i_raddr(m_raddr), .o_rdata(ent_r)
    );

    icm_ram #(.WIDTH($bits(t_result)), .DEPTH(TABLE_DEPTH)) u_res (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(r_wptr), .i_wdata(res_w),
        .i_re(l_re), .i_raddr(r_head), .o_rdata(res_r)
    );

    assign o_pop = (r_state == S_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_done  <= '0;
            r_oval  <= 1'b0;
        end else begin
            // Outside the retire slot, drop the word once the receiver takes it.
            if (r_oval && i_tready && r_state != S_ROUT) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cur  <= i_item;
                        r_wptr <= r_head;
                        r_k    <= '0;
                        case (i_item.cmd)
                            CMD_SUBMIT: r_state <= (r_count == FULL) ? S_RRD : S_SWR;
                            CMD_COMPL:  r_state <= (r_count == '0) ? S_IDLE : S_WRD;
                            CMD_DRAIN:  r_state <= (r_count == '0) ? S_IDLE : S_RRD;
                            default:    r_state <= S_IDLE;
                        endcase
                    end
                end
                S_WRD: begin
                    r_state <= S_WCMP;
                end
                S_WCMP: begin
                    // Stop past the completion's sequence number, on the first match or at the last live entry.
                    if (ent_r.seq > r_cur.seq || l_we || r_k + 1'b1 == r_count) begin
                        r_state <= S_CHK;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_wptr  <= inc(r_wptr);
                        r_state <= S_WRD;
                    end
                    if (l_we) begin
                        r_done[r_wptr] <= 1'b1;
                    end
                end
                S_CHK: begin
                    r_state <= (r_count != '0 && d) ? S_RRD : S_IDLE;
                end
                S_RRD: begin
                    r_state <= S_ROUT;
                end
                S_ROUT: begin
                    if (out_free) begin
                        r_oval  <= 1'b1;
                        r_odata <= {1'b0,
                                    d ? res_r.err : W_ERR'(0),
                                    d ? res_r.lat : W_TIME'(0),
                                    ent_r.attrs[45:30], ent_r.attrs[29:14],
                                    d, ent_r.attrs[13], ent_r.attrs[12],
                                    ent_r.attrs[11:8], ent_r.attrs[7:0],
                                    ent_r.len, ent_r.lba, ent_r.start, ent_r.seq};
                        r_done[r_head] <= 1'b0;
                        r_head  <= head_nx;
                        r_count <= r_count - 1'b1;
                        case (r_cur.cmd)
                            CMD_SUBMIT: begin
                                r_olast <= 1'b1;
                                r_state <= S_SWR;
                            end
                            CMD_COMPL: begin
                                r_olast <= (r_count == CW'(1)) || !r_done[head_nx];
                                r_state <= ((r_count == CW'(1)) || !r_done[head_nx])
                                           ? S_IDLE : S_RRD;
                            end
                            default: begin
                                r_olast <= (r_count == CW'(1));
                                r_state <= (r_count == CW'(1)) ? S_IDLE : S_RRD;
                            end
                        endcase
                    end
                end
                S_SWR: begin
                    r_done[r_tail] <= 1'b0;
                    r_tail  <= inc(r_tail);
                    r_count <= r_count + 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_tvalid = r_oval;
    assign o_tdata  = r_odata;
    assign o_tlast  = r_olast;
    assign o_count  = r_count;

endmodule

### tb/testbench.sv
// Self-checking testbench for io_completion_matcher: stream stimulus and a scoreboard.
// It predicts the retired IO records in submit order. Depends on icm_pkg and the RTL.

class io_match_scoreboard;
    // Field names of one retired record, in tdata order, then the last flag.
    static string fname[12] = '{"out_seq_id", "start_time", "out_lba", "out_length",
        "out_io_class", "out_operation", "out_flags", "out_device_id", "queue_depth",
        "latency", "out_error", "last"};

    typedef struct {
        bit [63:0] f[12];
    } rec_t;

    // Mirror of the matcher table.
    bit [31:0] tab_seq[64];
    bit [47:0] tab_start[64];
    bit [47:0] tab_lba[64];
    bit [31:0] tab_len[64];
    bit [7:0]  tab_class[64];
    bit [3:0]  tab_op[64];
    bit        tab_flush[64];
    bit        tab_fua[64];
    bit [15:0] tab_dev[64];
    bit [15:0] tab_depth[64];
    bit [47:0] tab_lat[64];
    bit [7:0]  tab_err[64];
    bit        tab_done[64];
    int        head;
    int        tail;
    int        count;
    bit [15:0] outstanding;
    bit [47:0] time_base;
    rec_t      retired_q[$];
    int        errors;

    function new();
        head = 0;
        tail = 0;
        count = 0;
        outstanding = 0;
        time_base = 0;
        errors = 0;
        foreach (tab_done[i]) tab_done[i] = 0;
    endfunction

    function bit [47:0] rebase(bit [47:0] ts);
        if (time_base == 0) time_base = ts;
        return ts - time_base;
    endfunction

    // Pop the oldest entry into the expected records.
    function void retire_oldest();
        rec_t r;
        bit d;
        d = tab_done[head];
        r.f[0] = tab_seq[head];
        r.f[1] = tab_start[head];
        r.f[2] = tab_lba[head];
        r.f[3] = tab_len[head];
        r.f[4] = tab_class[head];
        r.f[5] = tab_op[head];
        r.f[6] = {d, tab_fua[head], tab_flush[head]};
        r.f[7] = tab_dev[head];
        r.f[8] = tab_depth[head];
        r.f[9] = d ? tab_lat[head] : 48'd0;
        r.f[10] = d ? tab_err[head] : 8'd0;
        r.f[11] = 0;
        tab_done[head] = 0;
        head = (head + 1) % 64;
        count--;
        retired_q.push_back(r);
    endfunction

    // Note an accepted input word and predict the records it retires.
    function void note_word(bit [1:0] cmd, bit [199:0] d);
        bit [31:0] seq;
        bit [47:0] ts;
        bit [47:0] lba;
        bit [31:0] len;
        bit [47:0] t;
        int n0;
        int i;
        n0 = retired_q.size();
        seq = d[31:0];
        ts = d[79:32];
        lba = d[127:80];
        len = d[159:128];
        if (cmd == icm_pkg::CMD_SUBMIT) begin
            t = rebase(ts);
            if (count >= 64) retire_oldest();
            if (outstanding != 16'hFFFF) outstanding++;
            tab_seq[tail] = seq;
            tab_start[tail] = t;
            tab_lba[tail] = lba;
            tab_len[tail] = len;
            tab_class[tail] = d[167:160];
            tab_op[tail] = d[171:168];
            tab_flush[tail] = d[172];
            tab_fua[tail] = d[173];
            tab_dev[tail] = d[189:174];
            tab_depth[tail] = outstanding;
            tab_done[tail] = 0;
            tail = (tail + 1) % 64;
            count++;
        end else if (cmd == icm_pkg::CMD_COMPL) begin
            t = rebase(ts);
            if (outstanding != 0) outstanding--;
            for (int k = 0; k < count; k++) begin
                i = (head + k) % 64;
                if (tab_seq[i] > seq) break;
                if (!tab_done[i] && tab_lba[i] == lba && tab_len[i] == len) begin
                    tab_lat[i] = t - tab_start[i];
                    tab_err[i] = d[197:190];
                    tab_done[i] = 1;
                    break;
                end
            end
            while (count > 0 && tab_done[head]) retire_oldest();
        end else if (cmd == icm_pkg::CMD_DRAIN) begin
            while (count > 0) retire_oldest();
        end
        if (retired_q.size() > n0) retired_q[retired_q.size() - 1].f[11] = 1;
    endfunction

    // Compare one accepted output word against the oldest expectation.
    function void check_word(bit [263:0] d, bit lst);
        rec_t e;
        bit [63:0] got[12];
        if (retired_q.size() == 0) begin
            $display("%0t: unexpected record seq=%h", $realtime, d[31:0]);
            errors++;
            return;
        end
        e = retired_q.pop_front();
        got[0] = d[31:0];
        got[1] = d[79:32];
        got[2] = d[127:80];
        got[3] = d[159:128];
        got[4] = d[167:160];
        got[5] = d[171:168];
        got[6] = d[174:172];
        got[7] = d[190:175];
        got[8] = d[206:191];
        got[9] = d[254:207];
        got[10] = d[262:255];
        got[11] = lst;
        for (int k = 0; k < 12; k++) begin
            if (got[k] !== e.f[k]) begin
                $display("%0t: %s expected %h actual %h", $realtime, fname[k], e.f[k],
                         got[k]);
                errors++;
            end
        end
    endfunction
endclass

module testbench;
    import icm_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // seq_id, timestamp, lba, length, io_class, operation, flush_flag, fua_flag,
    // device_id, error_code, zero pad
    logic [W_IDATA-1:0] s_axis_tdata;
    // command
    logic [W_CMD-1:0]   s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // out_seq_id, start_time, out_lba, out_length, out_io_class, out_operation,
    // out_flags, out_device_id, queue_depth, latency, out_error, zero pad
    logic [W_ODATA-1:0] m_axis_tdata;
    logic               m_axis_tlast;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] CMD_BOGUS = 2'd3;   // reserved code, block ignores it

    io_match_scoreboard matcher_sb;
    int        phase;          // 0: sender idles more lightly, 1: receiver lighter, 2: none
    int        idle_cycles;
    bit [31:0] seq_next;
    bit [47:0] clock_ticks;

    io_completion_matcher DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    // Receiver: stall at random per phase, change only at the falling edge.
    always @(negedge i_clk) begin
        if (phase == 0)
            m_axis_tready <= ($urandom_range(0, 99) >= 45);
        else if (phase == 1)
            m_axis_tready <= ($urandom_range(0, 99) >= 25);
        else
            m_axis_tready <= 1'b1;
    end

    // Check every accepted output word; count cycles without any handshake.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            matcher_sb.check_word(m_axis_tdata, m_axis_tlast);
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Drive one word, hold it until accepted, then note it with the scoreboard.
    // Valid stays high past the falling edge; the next call drops or replaces it.
    task automatic send_word(input logic [1:0] cmd, input bit [31:0] seq,
                             input bit [47:0] ts, input bit [47:0] lba,
                             input bit [31:0] len, input bit [7:0] cls,
                             input bit [3:0] op, input bit fl, input bit fu,
                             input bit [15:0] dev, input bit [7:0] err);
        bit [199:0] d;
        d = {2'b00, err, dev, fu, fl, op, cls, len, lba, ts, seq};
        // Sender gaps before the word.
        while ((phase == 0 && $urandom_range(0, 99) < 25) ||
               (phase == 1 && $urandom_range(0, 99) < 45)) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        matcher_sb.note_word(cmd, d);
        @(negedge i_clk);
    endtask

    task automatic send_submit(input bit [47:0] lba, input bit [31:0] len);
        seq_next += $urandom_range(1, 3);
        clock_ticks += $urandom_range(1, 40);
        send_word(CMD_SUBMIT, seq_next, clock_ticks, lba, len, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    endtask

    // Complete one live entry picked at random, so that matches are common.
    task automatic send_match();
        int k;
        int i;
        k = $urandom_range(0, matcher_sb.count - 1);
        i = (matcher_sb.head + k) % 64;
        clock_ticks += $urandom_range(1, 40);
        send_word(CMD_COMPL, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : seq_next,
                  clock_ticks, matcher_sb.tab_lba[i], matcher_sb.tab_len[i], $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial begin
        int r;
        bit burst_done;
        matcher_sb = new();
        phase = 0;
        idle_cycles = 0;
        seq_next = 0;
        clock_ticks = 48'h1000;
        burst_done = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_SUBMIT;
        m_axis_tready = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: zero timestamp leaves the base uncaptured, then extremes.
        send_word(CMD_SUBMIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(CMD_SUBMIT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                  32'hFFFF_FFFF, 8'hFF, 4'hF, 1, 1, 16'hFFFF, 8'hFF);
        // Early completion of the all-ones entry: latency wraps.
        send_word(CMD_COMPL, 32'hFFFF_FFFF, 48'h10, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                  0, 0, 0, 0, 0, 8'hFF);
        // Complete the head: both retire in order.
        send_word(CMD_COMPL, 32'hFFFF_FFFF, 48'h20, 0, 0, 0, 0, 0, 0, 0, 8'h5A);
        // Duplicate submits with equal lba and length; out-of-order sequence too.
        send_word(CMD_SUBMIT, 10, 48'h100, 48'h77, 8, 1, 2, 1, 0, 3, 0);
        send_word(CMD_SUBMIT, 10, 48'h110, 48'h77, 8, 4, 5, 0, 1, 6, 0);
        send_word(CMD_SUBMIT, 5, 48'h120, 48'h99, 16, 7, 8, 1, 1, 9, 0);
        // No match: lba differs; then a sequence too small to reach anything.
        send_word(CMD_COMPL, 10, 48'h130, 48'h78, 8, 0, 0, 0, 0, 0, 1);
        send_word(CMD_COMPL, 4, 48'h140, 48'h77, 8, 0, 0, 0, 0, 0, 2);
        // The first completion retires one duplicate; the second matches and retires the other.
        send_word(CMD_COMPL, 10, 48'h150, 48'h77, 8, 0, 0, 0, 0, 0, 3);
        send_word(CMD_COMPL, 10, 48'h160, 48'h77, 8, 0, 0, 0, 0, 0, 4);
        send_word(CMD_BOGUS, 0, 48'h170, 48'h99, 16, 0, 0, 0, 0, 0, 0);
        send_word(CMD_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(CMD_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        seq_next = 20;

        // Random part: mostly submits and matching completions.
        for (int n = 0; n < 140; n++) begin
            phase = (n < 47) ? 0 : (n < 94) ? 1 : 2;
            r = $urandom_range(0, 99);
            if (!burst_done && n > 40 && r >= 94) begin
                // Overfill the table to force evictions.
                repeat (68) send_submit($urandom_range(0, 7), $urandom_range(1, 4));
                burst_done = 1;
            end else if (r < 45 || matcher_sb.count == 0) begin
                if ($urandom_range(0, 1))
                    send_submit($urandom_range(0, 7), $urandom_range(1, 4));
                else
                    send_submit({$urandom, $urandom}, $urandom);
            end else if (r < 85) begin
                send_match();
            end else if (r < 89) begin
                clock_ticks = {$urandom, $urandom};
                send_word(CMD_COMPL, $urandom, clock_ticks, $urandom_range(0, 7),
                          $urandom_range(1, 4), $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
            end else if (r < 92) begin
                send_word(CMD_DRAIN, $urandom, {$urandom, $urandom}, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 94) begin
                send_word(CMD_BOGUS, $urandom, {$urandom, $urandom}, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                // Sequence may go backward: still appended at the tail.
                seq_next -= $urandom_range(0, 5);
                send_submit($urandom_range(0, 7), $urandom_range(1, 4));
            end
        end
        send_word(CMD_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        s_axis_tvalid <= 1'b0;

        // Wait for the expectations to empty, then let the pipeline settle.
        while (matcher_sb.retired_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (matcher_sb.errors == 0 && matcher_sb.retired_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

### io_completion_matcher.f
rtl/icm_pkg.sv
rtl/icm_ram.sv
rtl/icm_fifo.sv
rtl/icm_front.sv
rtl/icm_back.sv
rtl/io_completion_matcher.sv
tb/testbench.sv
